// ----- rtl/substring_first_match_unit_assert.svh -----
`ifndef SUBSTRING_FIRST_MATCH_UNIT_ASSERT_SVH
`define SUBSTRING_FIRST_MATCH_UNIT_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define SFM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define SFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sfm_pkg.sv -----
package sfm_pkg;

  localparam int unsigned PATTERN_MAX = 16;
  localparam int unsigned TEXT_MAX    = 256;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned S_TDATA_W   = 8;
  localparam int unsigned M_TDATA_W   = 16;

  localparam logic FUNC_TEXT = 1'b1;

  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [1:0] {
    OP_PAT_CHAR,
    OP_PAT_END,
    OP_TEXT_CHAR,
    OP_TEXT_END
  } op_e;

  typedef struct packed {
    op_e   op;
    char_t char_code;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// ----- rtl/sfm_front.sv -----
module sfm_front
  import sfm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // char_code
  input  logic                 s_axis_tuser_i,  // func
  output queue_head_t          head_o,
  input  logic                 pop_i
);

  localparam logic [1:0] QueueFull  = 2'd2;
  localparam logic [1:0] QueueEmpty = 2'd0;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  item_t      item;

  always_comb begin
    item.char_code = s_axis_tdata_i[CHAR_W-1:0];
    if (s_axis_tuser_i == FUNC_TEXT) begin
      item.op = (s_axis_tdata_i == '0) ? OP_TEXT_END : OP_TEXT_CHAR;
    end else begin
      item.op = (s_axis_tdata_i == '0) ? OP_PAT_END : OP_PAT_CHAR;
    end
  end

  assign s_axis_tready_o = (cnt_q != QueueFull);
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = pop_i && (cnt_q != QueueEmpty);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= QueueEmpty;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  assign head_o.valid = (cnt_q != QueueEmpty);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

// ----- rtl/sfm_back.sv -----
module sfm_back
  import sfm_pkg::*;
#(
  parameter int unsigned PatternMax = PATTERN_MAX,
  parameter int unsigned TextMax    = TEXT_MAX
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  queue_head_t          head_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // found, match_start, pattern_truncated, zero fill
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned LW  = $clog2(PatternMax + 1);
  localparam int unsigned PW  = $clog2(TextMax + 1);
  localparam int unsigned IW0 = (PW > LW) ? PW : LW;
  localparam int unsigned IW  = (IW0 > INDEX_W) ? IW0 : INDEX_W;
  localparam int unsigned PadW = M_TDATA_W - INDEX_W - 2;

  char_t                  store_q [PatternMax];
  logic [LW-1:0]          len_q, len_d, eff_len;
  logic                   closed_q, closed_d;
  logic                   cut_q, cut_d, eff_cut;
  logic [PatternMax-1:0]  hits_q, hits_d, new_hits, last_lane;
  logic [PW-1:0]          pos_q, pos_d;
  logic                   seen_q, seen_d;
  logic [INDEX_W-1:0]     idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  logic [M_TDATA_W-1:0]   out_data_q, out_data_d;
  logic                   out_free, store_we, hit_end;
  logic [IW-1:0]          start;
  char_t                  c;

  assign c = head_i.item.char_code;

  for (genvar i = 0; i < PatternMax; i++) begin : g_lane
    logic prev;
    if (i == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = hits_q[i-1];
    end
    assign new_hits[i]  = prev && (store_q[i] == c) && (LW'(i) < len_q);
    assign last_lane[i] = (LW'(i + 1) == len_q);
  end

  assign hit_end  = |(new_hits & last_lane);
  assign start    = IW'(pos_q) + IW'(1) - IW'(len_q);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign pop_o    = head_i.valid && ((head_i.item.op != OP_TEXT_END) || out_free);
  assign eff_len  = closed_q ? '0 : len_q;
  assign eff_cut  = closed_q ? 1'b0 : cut_q;

  always_comb begin
    len_d       = len_q;
    closed_d    = closed_q;
    cut_d       = cut_q;
    hits_d      = hits_q;
    pos_d       = pos_q;
    seen_d      = seen_q;
    idx_d       = idx_q;
    store_we    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    if (pop_o) begin
      unique case (head_i.item.op)
        OP_PAT_CHAR, OP_PAT_END: begin
          hits_d   = '0;
          pos_d    = '0;
          seen_d   = 1'b0;
          idx_d    = '0;
          closed_d = 1'b0;
          len_d    = eff_len;
          cut_d    = eff_cut;
          if (head_i.item.op == OP_PAT_END) begin
            closed_d = 1'b1;
          end else if (eff_len < LW'(PatternMax)) begin
            store_we = 1'b1;
            len_d    = eff_len + LW'(1);
          end else begin
            cut_d = 1'b1;
          end
        end
        OP_TEXT_CHAR: begin
          closed_d = 1'b1;
          if (pos_q < PW'(TextMax)) begin
            hits_d = new_hits;
            pos_d  = pos_q + PW'(1);
            if (!seen_q && hit_end) begin
              seen_d = 1'b1;
              idx_d  = start[INDEX_W-1:0];
            end
          end
        end
        OP_TEXT_END: begin
          closed_d    = 1'b1;
          out_valid_d = 1'b1;
          out_data_d  = {PadW'(0), cut_q, (seen_q ? idx_q : '0), seen_q};
          hits_d      = '0;
          pos_d       = '0;
          seen_d      = 1'b0;
          idx_d       = '0;
        end
        default: begin
          closed_d = closed_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      closed_q    <= 1'b1;
      cut_q       <= 1'b0;
      hits_q      <= '0;
      pos_q       <= '0;
      seen_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      closed_q    <= closed_d;
      cut_q       <= cut_d;
      hits_q      <= hits_d;
      pos_q       <= pos_d;
      seen_q      <= seen_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    for (int i = 0; i < PatternMax; i++) begin
      if (store_we && (LW'(i) == eff_len)) begin
        store_q[i] <= c;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ----- rtl/substring_first_match_unit.sv -----
// Exact substring search over byte streams. Pattern bytes (tuser low) and text
// bytes (tuser high) arrive as NUL-terminated strings, one byte per transfer, and
// the unit takes one byte every clock cycle while its input queue has room. Each
// text byte is compared against every stored pattern byte at once in a
// shift-and bit vector, so the cost per byte does not grow with pattern length.
// A two-entry queue sits between the input classifier and the matching engine,
// and the result sits in an output register, so the input keeps flowing while a
// result waits. A text terminator passes through the queue and, when the output
// register is free, loads one result into it; the engine holds only while a
// finished result has not yet been taken. No other byte produces a result.
module substring_first_match_unit
  import sfm_pkg::*;
#(
  parameter int unsigned PatternMax = PATTERN_MAX,
  parameter int unsigned TextMax    = TEXT_MAX
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // char_code
  input  logic                 s_axis_tuser_i,  // func
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // found, match_start, pattern_truncated, zero fill
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  `include "substring_first_match_unit_assert.svh"

  queue_head_t head;
  logic        pop;

  sfm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .head_o          (head),
    .pop_i           (pop)
  );

  sfm_back #(
    .PatternMax (PatternMax),
    .TextMax    (TextMax)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  `SFM_ASSERT_NOW(a_start_zero_when_absent, m_axis_tvalid_o && !m_axis_tdata_o[0], m_axis_tdata_o[INDEX_W:1] == '0, "match start set without a match")
  `SFM_ASSERT_NEXT(a_result_loaded, pop && head.item.op == OP_TEXT_END, m_axis_tvalid_o, "text terminator did not load a result")
  `SFM_ASSERT_NOW(a_stall_only_on_result, head.valid && !pop, head.item.op == OP_TEXT_END && m_axis_tvalid_o && !m_axis_tready_i, "engine stalled without a pending result")

endmodule
